// File: hdl/crg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crg_pkg
// Types and fixed constants shared by the consecutive range grouper.
// ============================================================================
package crg_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int READ_COUNT_W = 7;
    localparam int COUNT_MAX    = 127;
    localparam int RESULT_LIMIT = 32;
    localparam int RUNS_W       = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]     range_start;
        logic [SAMPLE_W-1:0]     range_end;
        logic [READ_COUNT_W-1:0] reading_count;
        logic                    no_range;
        logic                    overflowed;
        logic                    last_result;
    } result_t;

    // Control broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: hdl/crg_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crg_cell
// One cell of the sorted insertion chain: holds one sample.
// ============================================================================
module crg_cell (
    input  wire logic                         clk,
    input  wire crg_pkg::cell_ctrl_t          ctrl,
    input  wire logic [crg_pkg::SAMPLE_W-1:0] new_value,
    input  wire logic                         occupied,
    input  wire logic                         left_gt,
    input  wire logic [crg_pkg::SAMPLE_W-1:0] left_value,
    input  wire logic [crg_pkg::SAMPLE_W-1:0] right_value,
    output logic                              gt,
    output logic [crg_pkg::SAMPLE_W-1:0]      value
);

    logic [crg_pkg::SAMPLE_W-1:0] value_reg;
    logic [crg_pkg::SAMPLE_W-1:0] value_next;

    // An empty cell counts as larger than any sample.
    assign gt    = !occupied || (value_reg > new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && gt)
        begin
            // take the left neighbour's sample if it moves too, else the new one
            value_next = left_gt ? left_value : new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

// File: hdl/crg_sort_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// crg_sort_chain
// Row of cells kept in ascending order; inserts one sample or pops the head.
// ============================================================================
module crg_sort_chain #(
    parameter int DEPTH = 64
) (
    input  wire logic                           clk,
    input  wire crg_pkg::cell_ctrl_t            ctrl,
    input  wire logic [crg_pkg::SAMPLE_W-1:0]   new_value,
    input  wire logic [$clog2(DEPTH+1)-1:0]     count,
    output logic [crg_pkg::SAMPLE_W-1:0]        head
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [crg_pkg::SAMPLE_W-1:0] cell_value [DEPTH];
    logic                         cell_gt    [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                         left_gt;
            logic [crg_pkg::SAMPLE_W-1:0] left_value;
            logic [crg_pkg::SAMPLE_W-1:0] right_value;
            logic                         occupied;

            assign occupied = CW'(i) < count;

            if (i == 0)
            begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = '0;
            end
            else
            begin : g_inner
                assign left_gt    = cell_gt[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_body
                assign right_value = cell_value[i+1];
            end

            crg_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_value   (new_value),
                .occupied    (occupied),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .right_value (right_value),
                .gt          (cell_gt[i]),
                .value       (cell_value[i])
            );
        end
    endgenerate

    assign head = cell_value[0];

endmodule
`default_nettype wire

// File: hdl/consecutive_range_grouper.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// consecutive_range_grouper
// Collects a batch of samples, sorts them and reports runs of close values.
// ============================================================================
// Samples are taken one per cycle (start high, busy low) and inserted at once
// into a row of MAX_SAMPLES cells that keep them in ascending order; a sample
// that finds the row full is dropped and the batch is marked overflowed. The
// transfer flagged last_sample ends the batch: busy then stays high while the
// head of the row is popped once per cycle into the run tracker (ST_WALK),
// then while the final run is closed (ST_FLUSH) and the last result is issued
// (ST_FINISH). Each run of two or more samples whose neighbours differ by 0
// or 1 gives one result, in ascending order, at most 32 per batch; a batch
// without such a run gives a single no_range result. Results appear on result
// for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take every transfer. A result trails the run that made it by
// one run, so that the final one can carry last_result; the last result
// appears in the same cycle as busy falls. reading_count saturates at 127.
// ============================================================================
module consecutive_range_grouper #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire crg_pkg::in_item_t item,
    output crg_pkg::result_t       result,
    output logic                   result_valid
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = crg_pkg::SAMPLE_W;

    crg_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                      count_reg, count_next;
    logic                               overflow_reg, overflow_next;
    logic                               first_reg, first_next;
    logic [SW-1:0]                      prev_reg, prev_next;
    logic [SW-1:0]                      start_reg, start_next;
    logic [CW-1:0]                      len_reg, len_next;
    logic [crg_pkg::RUNS_W-1:0]         emitted_reg, emitted_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [SW-1:0]                      pend_start_reg, pend_start_next;
    logic [SW-1:0]                      pend_end_reg, pend_end_next;
    logic [crg_pkg::READ_COUNT_W-1:0]   pend_count_reg, pend_count_next;
    crg_pkg::result_t                   result_reg, result_next;
    logic                               result_valid_reg, result_valid_next;

    crg_pkg::cell_ctrl_t                ctrl;
    logic [SW-1:0]                      head;
    logic                               accept;
    logic                               full;
    logic                               extend;
    logic                               close_ok;
    logic [31:0]                        len_wide;
    logic [crg_pkg::READ_COUNT_W-1:0]   len_sat;
    logic [SW:0]                        step;

    assign busy         = state_reg != crg_pkg::ST_IDLE;
    assign accept       = start && !busy;
    assign full         = count_reg == CW'(MAX_SAMPLES);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Sorted row of cells: insert on a stored transfer, pop the head while walking.
    crg_sort_chain #(
        .DEPTH (MAX_SAMPLES)
    ) u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_value (item.sample),
        .count     (count_reg),
        .head      (head)
    );

    // Samples leave the row in ascending order, so the step is never negative.
    assign step     = {1'b0, head} - {1'b0, prev_reg};
    assign extend   = step <= (SW+1)'(1);
    assign len_wide = 32'(len_reg);
    assign len_sat  = (len_wide > 32'(crg_pkg::COUNT_MAX))
                      ? crg_pkg::READ_COUNT_W'(crg_pkg::COUNT_MAX)
                      : len_wide[crg_pkg::READ_COUNT_W-1:0];
    // A closing run is kept only if it holds two or more and there is room.
    assign close_ok = (len_reg >= CW'(2))
                      && (emitted_reg < crg_pkg::RUNS_W'(crg_pkg::RESULT_LIMIT));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crg_pkg::ST_IDLE:
            begin
                if (accept && item.last_sample)
                begin
                    state_next = crg_pkg::ST_WALK;
                end
            end
            crg_pkg::ST_WALK:
            begin
                if (count_reg == CW'(1))
                begin
                    state_next = crg_pkg::ST_FLUSH;
                end
            end
            crg_pkg::ST_FLUSH:
            begin
                state_next = crg_pkg::ST_FINISH;
            end
            crg_pkg::ST_FINISH:
            begin
                state_next = crg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crg_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        ctrl              = '0;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        first_next        = first_reg;
        prev_next         = prev_reg;
        start_next        = start_reg;
        len_next          = len_reg;
        emitted_next      = emitted_reg;
        pend_valid_next   = pend_valid_reg;
        pend_start_next   = pend_start_reg;
        pend_end_next     = pend_end_reg;
        pend_count_next   = pend_count_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        case (state_reg)
            crg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // store the sample, or drop it and mark the batch
                    if (!full)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (item.last_sample)
                    begin
                        first_next      = 1'b1;
                        emitted_next    = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            crg_pkg::ST_WALK:
            begin
                ctrl.shift = 1'b1;
                count_next = count_reg - CW'(1);
                prev_next  = head;
                first_next = 1'b0;
                if (first_reg)
                begin
                    start_next = head;
                    len_next   = CW'(1);
                end
                else if (extend)
                begin
                    len_next = len_reg + CW'(1);
                end
                else
                begin
                    // close the run: issue the held one, hold this one
                    if (close_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            result_valid_next         = 1'b1;
                            result_next.range_start   = pend_start_reg;
                            result_next.range_end     = pend_end_reg;
                            result_next.reading_count = pend_count_reg;
                            result_next.no_range      = 1'b0;
                            result_next.overflowed    = overflow_reg;
                            result_next.last_result   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = start_reg;
                        pend_end_next   = prev_reg;
                        pend_count_next = len_sat;
                        emitted_next    = emitted_reg + crg_pkg::RUNS_W'(1);
                    end
                    start_next = head;
                    len_next   = CW'(1);
                end
            end
            crg_pkg::ST_FLUSH:
            begin
                // close the final run of the batch
                if (close_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.range_start   = pend_start_reg;
                        result_next.range_end     = pend_end_reg;
                        result_next.reading_count = pend_count_reg;
                        result_next.no_range      = 1'b0;
                        result_next.overflowed    = overflow_reg;
                        result_next.last_result   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_start_next = start_reg;
                    pend_end_next   = prev_reg;
                    pend_count_next = len_sat;
                    emitted_next    = emitted_reg + crg_pkg::RUNS_W'(1);
                end
            end
            crg_pkg::ST_FINISH:
            begin
                result_valid_next       = 1'b1;
                result_next.overflowed  = overflow_reg;
                result_next.last_result = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next.range_start   = pend_start_reg;
                    result_next.range_end     = pend_end_reg;
                    result_next.reading_count = pend_count_reg;
                    result_next.no_range      = 1'b0;
                end
                else
                begin
                    result_next.range_start   = '0;
                    result_next.range_end     = '0;
                    result_next.reading_count = '0;
                    result_next.no_range      = 1'b1;
                end
                // empty the batch
                count_next      = '0;
                overflow_next   = 1'b0;
                pend_valid_next = 1'b0;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= crg_pkg::ST_IDLE;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            first_reg        <= 1'b0;
            emitted_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            first_reg        <= first_next;
            emitted_reg      <= emitted_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        pend_count_reg <= pend_count_next;
        result_reg     <= result_next;
    end

`ifndef SYNTHESIS
    // Walk keeps going while samples remain in the row.
    a_walk_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crg_pkg::ST_WALK && count_reg > CW'(1))
        |=> state_reg == crg_pkg::ST_WALK)
        else $error("walk ended with samples left");

    // A final sample always starts the walk.
    a_last_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_sample) |=> state_reg == crg_pkg::ST_WALK)
        else $error("batch end did not start the walk");

    // A no_range result is the only and final one, with zero count.
    a_no_range_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.no_range)
        |-> (result_reg.last_result && result_reg.reading_count == '0))
        else $error("malformed no_range result");

    // A reported run holds two or more and is ordered.
    a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.no_range)
        |-> (result_reg.reading_count >= crg_pkg::READ_COUNT_W'(2)
             && result_reg.range_end >= result_reg.range_start))
        else $error("malformed run result");

    // The last result closes the batch: nothing remains held.
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crg_pkg::ST_FINISH)
        |=> (!pend_valid_reg && count_reg == '0 && !overflow_reg
             && result_valid_reg && result_reg.last_result))
        else $error("batch not emptied after last result");
`endif

endmodule
`default_nettype wire
